FILE: rtl/core/tsag_pkg.sv
// Shared types and constants for the trailing-silence trim and auto-gain block.
// Used by the command queue, the divider, the engine and the top level.
package tsag_pkg;

  // Command codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_VAD_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_KEEP_MS       = 2'd1;
  localparam logic [1:0] REG_AUTO_GAIN     = 2'd2;
  localparam logic [1:0] REG_MANUAL_GAIN   = 2'd3;

  // Arithmetic constants
  localparam logic [16:0] UNITY_Q12     = 17'd4096;
  localparam logic [16:0] GAIN_MAX_Q12  = 17'd81920;
  localparam logic [20:0] UNITY_LOW     = 21'd4092;
  localparam logic [20:0] UNITY_HIGH    = 21'd4100;
  localparam logic [13:0] VOICE_SCALE   = 14'd15625;
  localparam logic [21:0] RMS_FLOOR     = 22'd4096;
  localparam logic [6:0]  RMS_MUL       = 7'd75;
  localparam logic [16:0] PEAK_MIN      = 17'd33;
  localparam logic [31:0] HALF_SCALE_Q  = 32'd67108864;

  // Divide by 1000 as a multiply by ceil(2^38 / 1000) and a shift, exact below 2^32
  localparam logic [28:0] MS_RECIP      = 29'd274877907;
  localparam int          MS_SHIFT      = 38;

  localparam int QUEUE_DEPTH = 4;
  localparam int DIV_W       = 32;
  localparam int DIVISOR_W   = 17;

  typedef struct packed {
    logic               op;
    logic signed [15:0] sample;
    logic               last;
  } cmd_t;

  typedef struct packed {
    logic [14:0]        vad_threshold;
    logic signed [15:0] keep_trailing_ms;
    logic               auto_gain_enable;
    logic [15:0]        manual_gain;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RHS_SQ,
    ST_RHS_MUL,
    ST_WIN_RUN,
    ST_WIN_CHECK,
    ST_KEEP_DIV,
    ST_KEEP_WAIT,
    ST_PEAK_SET,
    ST_PEAK_RUN,
    ST_GAIN_DIV,
    ST_GAIN_WAIT,
    ST_GAIN_MUL,
    ST_GAIN_SET,
    ST_FETCH_RD,
    ST_FETCH_MUL,
    ST_FETCH_RND
  } eng_state_t;

endpackage

FILE: rtl/core/tsag_queue.sv
// Command queue between the accepting front and the processing engine.
// Depends on tsag_pkg for the command type and queue depth.
module tsag_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_stall,
  input  tsag_pkg::cmd_t push_item,
  output logic          pop_valid,
  input  logic          pop_ready,
  output tsag_pkg::cmd_t pop_item
);
  import tsag_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t           slots [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [PW:0]    count;
  logic           do_push;
  logic           do_pop;

  assign push_stall = (count == (PW+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && !push_stall;
  assign do_pop     = pop_valid && pop_ready;

  // Store an accepted transaction
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/core/tsag_div.sv
// Restoring divider, one quotient bit per cycle, used by the engine for the gain.
// Depends on tsag_pkg for the operand widths.
module tsag_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [tsag_pkg::DIV_W-1:0]      dividend,
  input  logic [tsag_pkg::DIVISOR_W-1:0]  divisor,
  output logic                            done,
  output logic [tsag_pkg::DIV_W-1:0]      quotient
);
  import tsag_pkg::*;

  localparam int CW = $clog2(DIV_W + 1);

  logic [DIVISOR_W-1:0] dsr;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W:0]   rem_sh;
  logic [DIV_W-1:0]     quo;
  logic [CW-1:0]        steps;
  logic                 busy;
  logic                 fits;

  assign rem_sh   = {rem, quo[DIV_W-1]};
  assign fits     = (rem_sh >= {1'b0, dsr});
  assign quotient = quo;

  // Shift one dividend bit into the remainder per step
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= '0;
      end else if (busy) begin
        steps <= steps + 1'b1;
        if (steps == CW'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= DIVISOR_W'(rem_sh - {1'b0, dsr});
      end else begin
        rem <= rem_sh[DIVISOR_W-1:0];
      end
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

endmodule

FILE: rtl/core/tsag_engine.sv
// Back end: sample store, trim walk, peak scan, gain setup and fetch datapath.
// Depends on tsag_pkg and instantiates tsag_div.
module tsag_engine #(
  parameter int SAMPLE_RATE    = 16000,
  parameter int MAX_SAMPLES    = 524288,
  parameter int WINDOW_SAMPLES = 320
) (
  input  logic                clk,
  input  logic                rst,
  input  tsag_pkg::cfg_t      cfg,
  input  logic                cmd_valid,
  input  tsag_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  input  logic                res_stall,
  output logic                res_valid,
  output logic signed [15:0]  out_sample,
  output logic                out_valid,
  output logic                out_last
);
  import tsag_pkg::*;

  localparam int AW     = $clog2(MAX_SAMPLES);
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int WIN_CW = $clog2(WINDOW_SAMPLES + 1);
  localparam int SUM_W  = 31 + WIN_CW;
  localparam int LHS_W  = SUM_W + 14;
  localparam int RHS_W  = 44 + WIN_CW;
  localparam int CMP_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;
  localparam logic [CNT_W-1:0] WIN_LEN = CNT_W'(WINDOW_SAMPLES);
  localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(MAX_SAMPLES);

  eng_state_t state, state_next;

  // Sample store
  logic [15:0]        mem [MAX_SAMPLES];
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic signed [15:0] rd_data;

  // Capture bookkeeping
  logic             ready;
  logic [CNT_W-1:0] loaded;
  logic [CNT_W-1:0] kept;
  logic [CNT_W-1:0] rpos;
  logic [20:0]      tgain;
  logic [CNT_W-1:0] load_base;

  // Trim walk and peak scan
  logic [43:0]        uu;
  logic [RHS_W-1:0]   rhs;
  logic [CNT_W-1:0]   win_end;
  logic [CNT_W-1:0]   voice_end;
  logic [CNT_W-1:0]   issue;
  logic [CNT_W-1:0]   acc_cnt;
  logic [SUM_W-1:0]   acc;
  logic [16:0]        peak;
  logic               scan_rd;
  logic               rd_v;
  logic               sq_v;
  logic [30:0]        sq_q;
  logic [16:0]        abs_q;
  logic [21:0]        rms_u;
  logic [CMP_W-1:0]   lhs_cmp;
  logic               is_voice;
  logic [CNT_W-1:0]   win_prev;
  logic [32:0]        trim_sum;
  logic [DIV_W-1:0]   keep_prod;
  logic [DIV_W-1:0]   keep_q;

  // Gain setup
  logic [16:0] autog;
  logic [32:0] gprod;

  // Fetch datapath
  logic signed [15:0] samp_q;
  logic signed [37:0] prod_q;
  logic [37:0]        mag;
  logic [25:0]        rmag;
  logic signed [15:0] scaled;
  logic               fetch_ok;

  // Divider
  logic                 div_start;
  logic [DIV_W-1:0]     div_dividend;
  logic [DIVISOR_W-1:0] div_divisor;
  logic                 div_done;
  logic [DIV_W-1:0]     div_q;

  tsag_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign load_base = ready ? '0 : loaded;
  assign wr_en     = cmd_pop && (cmd.op == OP_LOAD) && (load_base < MAX_LEN);
  assign wr_addr   = load_base[AW-1:0];
  assign fetch_ok  = ready && (rpos < kept);
  assign rms_u     = ((22'(cfg.vad_threshold) * 22'(RMS_MUL)) < RMS_FLOOR) ?
                     RMS_FLOOR : 22'(cfg.vad_threshold) * 22'(RMS_MUL);
  assign lhs_cmp   = CMP_W'(acc) * CMP_W'(VOICE_SCALE);
  assign is_voice  = lhs_cmp > CMP_W'(rhs);
  assign win_prev  = win_end - WIN_LEN;
  assign trim_sum  = 33'(voice_end) + {1'b0, keep_q};

  // Write and read the store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd.sample;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Next state and controls
  always_comb begin
    state_next   = state;
    cmd_pop      = 1'b0;
    scan_rd      = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = '0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.op == OP_LOAD) begin
            cmd_pop = 1'b1;
            if (cmd.last) state_next = ST_RHS_SQ;
          end else if (!res_valid) begin
            cmd_pop = 1'b1;
            if (fetch_ok) state_next = ST_FETCH_RD;
          end
        end
      end
      ST_RHS_SQ: state_next = ST_RHS_MUL;
      ST_RHS_MUL: begin
        if (cfg.keep_trailing_ms[15])  state_next = ST_PEAK_SET;
        else if (loaded >= WIN_LEN)    state_next = ST_WIN_RUN;
        else                           state_next = ST_KEEP_DIV;
      end
      ST_WIN_RUN: begin
        if (issue < WIN_LEN) begin
          scan_rd = 1'b1;
          rd_en   = 1'b1;
          rd_addr = AW'(win_prev + issue);
        end
        if (acc_cnt == WIN_LEN) state_next = ST_WIN_CHECK;
      end
      ST_WIN_CHECK: begin
        if (is_voice)               state_next = ST_KEEP_DIV;
        else if (win_prev >= WIN_LEN) state_next = ST_WIN_RUN;
        else                        state_next = ST_KEEP_DIV;
      end
      ST_KEEP_DIV: state_next = ST_KEEP_WAIT;
      ST_KEEP_WAIT: state_next = ST_PEAK_SET;
      ST_PEAK_SET: state_next = (kept == '0) ? ST_GAIN_DIV : ST_PEAK_RUN;
      ST_PEAK_RUN: begin
        if (issue < kept) begin
          scan_rd = 1'b1;
          rd_en   = 1'b1;
          rd_addr = issue[AW-1:0];
        end
        if (acc_cnt == kept) state_next = ST_GAIN_DIV;
      end
      ST_GAIN_DIV: begin
        if (cfg.auto_gain_enable && (peak >= PEAK_MIN)) begin
          div_start    = 1'b1;
          div_dividend = HALF_SCALE_Q;
          div_divisor  = peak;
          state_next   = ST_GAIN_WAIT;
        end else begin
          state_next = ST_GAIN_MUL;
        end
      end
      ST_GAIN_WAIT: if (div_done) state_next = ST_GAIN_MUL;
      ST_GAIN_MUL: state_next = ST_GAIN_SET;
      ST_GAIN_SET: state_next = ST_IDLE;
      ST_FETCH_RD: begin
        rd_en      = 1'b1;
        rd_addr    = rpos[AW-1:0];
        state_next = ST_FETCH_MUL;
      end
      ST_FETCH_MUL: state_next = ST_FETCH_RND;
      ST_FETCH_RND: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Round half away from zero and clip to int16
  always_comb begin
    mag  = prod_q[37] ? 38'(-prod_q) : 38'(prod_q);
    rmag = 26'((mag + 38'd2048) >> 12);
    if (!prod_q[37]) begin
      scaled = (rmag > 26'd32767) ? 16'sd32767 : $signed(rmag[15:0]);
    end else begin
      scaled = (rmag > 26'd32768) ? -16'sd32768 : $signed(16'(-rmag[16:0]));
    end
  end

  // Scan pipeline: read, square or magnitude, accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
      sq_v <= 1'b0;
    end else begin
      rd_v <= scan_rd;
      sq_v <= rd_v;
    end
  end

  always_ff @(posedge clk) begin
    sq_q  <= 31'(rd_data * rd_data);
    abs_q <= rd_data[15] ? 17'(-{rd_data[15], rd_data}) : 17'({1'b0, rd_data});
  end

  // Control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ready     <= 1'b0;
      loaded    <= '0;
      kept      <= '0;
      rpos      <= '0;
      tgain     <= 21'(UNITY_Q12);
      res_valid <= 1'b0;
    end else begin
      if (res_valid && !res_stall) res_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (cmd_pop && (cmd.op == OP_LOAD)) begin
            ready  <= 1'b0;
            kept   <= '0;
            rpos   <= '0;
            loaded <= wr_en ? load_base + 1'b1 : load_base;
          end else if (cmd_pop && !fetch_ok) begin
            res_valid  <= 1'b1;
            out_sample <= '0;
            out_valid  <= 1'b0;
            out_last   <= 1'b0;
          end
        end
        ST_RHS_SQ: begin
          uu        <= 44'(rms_u) * 44'(rms_u);
          keep_prod <= DIV_W'(SAMPLE_RATE) * DIV_W'(cfg.keep_trailing_ms[14:0]);
          win_end   <= loaded;
          voice_end <= loaded;
        end
        ST_RHS_MUL: begin
          rhs     <= RHS_W'(uu) * RHS_W'(WINDOW_SAMPLES);
          kept    <= loaded;
          issue   <= '0;
          acc_cnt <= '0;
          acc     <= '0;
        end
        ST_WIN_RUN: begin
          if (scan_rd) issue <= issue + 1'b1;
          if (sq_v) begin
            acc     <= acc + SUM_W'(sq_q);
            acc_cnt <= acc_cnt + 1'b1;
          end
        end
        ST_WIN_CHECK: begin
          if (is_voice) voice_end <= win_end;
          win_end <= win_prev;
          issue   <= '0;
          acc_cnt <= '0;
          acc     <= '0;
        end
        // Kept time in samples: divide by 1000 through the reciprocal
        ST_KEEP_DIV: keep_q <= DIV_W'((61'(keep_prod) * 61'(MS_RECIP)) >> MS_SHIFT);
        ST_KEEP_WAIT: kept <= (trim_sum < 33'(loaded)) ? CNT_W'(trim_sum) : loaded;
        ST_PEAK_SET: begin
          issue   <= '0;
          acc_cnt <= '0;
          peak    <= '0;
        end
        ST_PEAK_RUN: begin
          if (scan_rd) issue <= issue + 1'b1;
          if (sq_v) begin
            if (abs_q > peak) peak <= abs_q;
            acc_cnt <= acc_cnt + 1'b1;
          end
        end
        ST_GAIN_DIV: autog <= UNITY_Q12;
        ST_GAIN_WAIT: begin
          if (div_done) begin
            if (div_q > DIV_W'(GAIN_MAX_Q12))      autog <= GAIN_MAX_Q12;
            else if (div_q < DIV_W'(UNITY_Q12))    autog <= UNITY_Q12;
            else                                   autog <= div_q[16:0];
          end
        end
        ST_GAIN_MUL: gprod <= 33'(autog) * 33'(cfg.manual_gain);
        ST_GAIN_SET: begin
          tgain <= gprod[32:12];
          rpos  <= '0;
          ready <= 1'b1;
        end
        ST_FETCH_MUL: begin
          samp_q <= rd_data;
          prod_q <= 38'(rd_data) * $signed({17'd0, tgain});
        end
        ST_FETCH_RND: begin
          res_valid  <= 1'b1;
          out_valid  <= 1'b1;
          out_last   <= (rpos + 1'b1 == kept);
          rpos       <= rpos + 1'b1;
          out_sample <= ((tgain >= UNITY_LOW) && (tgain <= UNITY_HIGH)) ? samp_q : scaled;
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/trailing_silence_trim_auto_gain.sv
// Trailing-silence trim with peak normalization. Loads stream in back to back
// through a four-entry command queue while the engine is idle. The load marked
// last starts a walk of windows back from the end, one store read per cycle,
// unless the keep time is negative; then follow a reciprocal multiply for the
// kept time (also skipped when negative), a peak scan over the kept samples and,
// with auto gain on and a large enough peak, a divide for the gain. The length
// of the whole pass is set by the single store read port.
// A fetch steps through store read, gain multiply and rounding.
// A fetch result waits in an output register while further loads are taken.
// Top level: configuration registers, command queue and processing engine.
// Depends on tsag_pkg, tsag_queue and tsag_engine.
module trailing_silence_trim_auto_gain #(
  parameter int SAMPLE_RATE    = 16000,
  parameter int MAX_SAMPLES    = 524288,
  parameter int WINDOW_SAMPLES = 320
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               opcode,
  input  logic signed [15:0] in_sample,
  input  logic               in_last,
  output logic               res_valid,
  input  logic               res_stall,
  output logic signed [15:0] out_sample,
  output logic               out_valid,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import tsag_pkg::*;

  cfg_t cfg;
  cmd_t in_cmd;
  cmd_t q_cmd;
  logic q_valid;
  logic q_pop;

  assign cfg_ready = 1'b1;
  assign in_cmd    = '{op: opcode, sample: in_sample, last: in_last};

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.vad_threshold    <= 15'd328;
      cfg.keep_trailing_ms <= 16'sd300;
      cfg.auto_gain_enable <= 1'b1;
      cfg.manual_gain      <= 16'd4096;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_VAD_THRESHOLD: cfg.vad_threshold    <= cfg_data[14:0];
        REG_KEEP_MS:       cfg.keep_trailing_ms <= $signed(cfg_data);
        REG_AUTO_GAIN:     cfg.auto_gain_enable <= cfg_data[0];
        REG_MANUAL_GAIN:   cfg.manual_gain      <= cfg_data;
        default: ;
      endcase
    end
  end

  tsag_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_stall (in_stall),
    .push_item  (in_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_pop),
    .pop_item   (q_cmd)
  );

  tsag_engine #(
    .SAMPLE_RATE    (SAMPLE_RATE),
    .MAX_SAMPLES    (MAX_SAMPLES),
    .WINDOW_SAMPLES (WINDOW_SAMPLES)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd_valid  (q_valid),
    .cmd        (q_cmd),
    .cmd_pop    (q_pop),
    .res_stall  (res_stall),
    .res_valid  (res_valid),
    .out_sample (out_sample),
    .out_valid  (out_valid),
    .out_last   (out_last)
  );

endmodule
